[src/jmpd_pkg.sv]
// shared types and constants for the joystick motor drive
`default_nettype none

package jmpd_pkg;

	localparam int FRAME_W = 16;
	localparam int CNT_W   = 10;
	localparam int CFG_W   = 10;
	localparam int IDX_W   = 3;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DEAD_BAND   = 3'd0,
		REG_PWM_PERIOD  = 3'd1,
		REG_GREEN_MIN   = 3'd2,
		REG_YELLOW_MIN  = 3'd3,
		REG_ORANGE_MIN  = 3'd4,
		REG_BLINK_LEVEL = 3'd5
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] DEAD_BAND_RST   = 10'd12;
	localparam logic [CFG_W-1:0] PWM_PERIOD_RST  = 10'd999;
	localparam logic [CFG_W-1:0] GREEN_MIN_RST   = 10'd915;
	localparam logic [CFG_W-1:0] YELLOW_MIN_RST  = 10'd813;
	localparam logic [CFG_W-1:0] ORANGE_MIN_RST  = 10'd608;
	localparam logic [CFG_W-1:0] BLINK_LEVEL_RST = 10'd500;

	// motor pattern, bit 0 motor a forward, 1 a reverse, 2 b forward, 3 b reverse
	typedef logic [3:0] drive_t;

	localparam drive_t DRV_OFF     = 4'b0000;
	localparam drive_t DRV_FORWARD = 4'b0101;
	localparam drive_t DRV_BACK    = 4'b1010;
	localparam drive_t DRV_RIGHT   = 4'b0100;
	localparam drive_t DRV_LEFT    = 4'b0001;

	typedef struct packed {
		logic [CFG_W-1:0] dead_band;
		logic [CFG_W-1:0] pwm_period;
		logic [CFG_W-1:0] green_min;
		logic [CFG_W-1:0] yellow_min;
		logic [CFG_W-1:0] orange_min;
		logic [CFG_W-1:0] blink_level;
	} cfg_t;

	typedef struct packed {
		logic [FRAME_W-1:0] forward_frame;
		logic [FRAME_W-1:0] side_frame;
		logic [FRAME_W-1:0] battery_frame;
		logic [CNT_W-1:0]   pwm_count;
		logic               power_on;
	} sample_t;

	typedef struct packed {
		drive_t drive;
		logic   led_red;
		logic   led_orange;
		logic   led_yellow;
		logic   led_green;
	} result_t;

endpackage

`default_nettype wire

[src/jmpd_ifs.sv]
// handshake channels: sample in, result out, register writes
`default_nettype none

interface jmpd_sample_if;
	logic                         valid;
	logic                         ready;
	logic [jmpd_pkg::FRAME_W-1:0] forward_frame;
	logic [jmpd_pkg::FRAME_W-1:0] side_frame;
	logic [jmpd_pkg::FRAME_W-1:0] battery_frame;
	logic [jmpd_pkg::CNT_W-1:0]   pwm_count;
	logic                         power_on;

	modport source (output valid, forward_frame, side_frame, battery_frame, pwm_count,
		power_on, input ready);
	modport sink (input valid, forward_frame, side_frame, battery_frame, pwm_count,
		power_on, output ready);
endinterface

interface jmpd_result_if;
	logic valid;
	logic ready;
	logic motor_a_forward;
	logic motor_a_reverse;
	logic motor_b_forward;
	logic motor_b_reverse;
	logic led_red;
	logic led_orange;
	logic led_yellow;
	logic led_green;

	modport source (output valid, motor_a_forward, motor_a_reverse, motor_b_forward,
		motor_b_reverse, led_red, led_orange, led_yellow, led_green, input ready);
	modport sink (input valid, motor_a_forward, motor_a_reverse, motor_b_forward,
		motor_b_reverse, led_red, led_orange, led_yellow, led_green, output ready);
endinterface

interface jmpd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [jmpd_pkg::IDX_W-1:0] index;
	logic [jmpd_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/joystick_motor_pwm_drive.sv]
// joystick motor drive: result register loads when a sample word leaves the input stage
// one sample word per clock while the result register is not stalled; ready drops
// only then; the decision logic between input and result regs is combinational
// reset clears the stage valids and the held motor pattern, and loads default registers
// register writes are taken every cycle and apply from the next sample processed
`default_nettype none

module joystick_motor_pwm_drive #(
	parameter int CODE_BITS  = 10,
	parameter int CODE_SHIFT = 3
) (
	input  wire             clk,
	input  wire             arst_n,
	jmpd_sample_if.sink     sample,
	jmpd_result_if.source   result,
	jmpd_cfg_if.sink        cfg
);
	import jmpd_pkg::*;

	cfg_t    cfg_q;
	sample_t sample_s1;
	logic    valid_s1;
	logic    adv_s1;
	result_t res_c;
	drive_t  held_nx;
	drive_t  held_q;
	result_t res_q;
	logic    out_valid_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_band   <= DEAD_BAND_RST;
			cfg_q.pwm_period  <= PWM_PERIOD_RST;
			cfg_q.green_min   <= GREEN_MIN_RST;
			cfg_q.yellow_min  <= YELLOW_MIN_RST;
			cfg_q.orange_min  <= ORANGE_MIN_RST;
			cfg_q.blink_level <= BLINK_LEVEL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEAD_BAND:   cfg_q.dead_band   <= cfg.data;
				REG_PWM_PERIOD:  cfg_q.pwm_period  <= cfg.data;
				REG_GREEN_MIN:   cfg_q.green_min   <= cfg.data;
				REG_YELLOW_MIN:  cfg_q.yellow_min  <= cfg.data;
				REG_ORANGE_MIN:  cfg_q.orange_min  <= cfg.data;
				REG_BLINK_LEVEL: cfg_q.blink_level <= cfg.data;
				default: ;
			endcase
		end
	end

	// input stage
	assign adv_s1 = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1.forward_frame <= sample.forward_frame;
			sample_s1.side_frame    <= sample.side_frame;
			sample_s1.battery_frame <= sample.battery_frame;
			sample_s1.pwm_count     <= sample.pwm_count;
			sample_s1.power_on      <= sample.power_on;
		end
	end

	jmpd_decide #(
		.CODE_BITS  (CODE_BITS),
		.CODE_SHIFT (CODE_SHIFT)
	) u_decide (
		.smp     (sample_s1),
		.cfg     (cfg_q),
		.held    (held_q),
		.res     (res_c),
		.held_nx (held_nx)
	);

	// held pattern moves with the word that leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= DRV_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				held_q <= held_nx;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_c;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.motor_a_forward = res_q.drive[0];
	assign result.motor_a_reverse = res_q.drive[1];
	assign result.motor_b_forward = res_q.drive[2];
	assign result.motor_b_reverse = res_q.drive[3];
	assign result.led_red         = res_q.led_red;
	assign result.led_orange      = res_q.led_orange;
	assign result.led_yellow      = res_q.led_yellow;
	assign result.led_green       = res_q.led_green;

`ifndef SYNTHESIS
	a_no_shoot_through: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.motor_a_forward && result.motor_a_reverse) &&
			!(result.motor_b_forward && result.motor_b_reverse))
		else $error("motor driven both ways");

	a_one_led: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> $onehot0({result.led_red, result.led_orange,
			result.led_yellow, result.led_green}))
		else $error("more than one battery led lit");

	a_held_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> held_q == res_q.drive)
		else $error("held motor pattern differs from last result");

	a_stage_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(sample_s1))
		else $error("stalled input stage lost its word");
`endif

endmodule

`default_nettype wire

[src/jmpd_decide.sv]
// per-sample decision: axis magnitudes, dead band, duty compare, led select
`default_nettype none

module jmpd_decide #(
	parameter int CODE_BITS  = 10,
	parameter int CODE_SHIFT = 3
) (
	input  jmpd_pkg::sample_t smp,
	input  jmpd_pkg::cfg_t    cfg,
	input  jmpd_pkg::drive_t  held,
	output jmpd_pkg::result_t res,
	output jmpd_pkg::drive_t  held_nx
);
	import jmpd_pkg::*;

	localparam int XW = FRAME_W + CODE_BITS;
	localparam int MW = (CODE_BITS > CFG_W) ? CODE_BITS : CFG_W;
	localparam int PW = CODE_BITS + CFG_W + 1;
	localparam logic [CODE_BITS-1:0] FULL = {CODE_BITS{1'b1}};

	function automatic logic [CODE_BITS-1:0] code_of(input logic [FRAME_W-1:0] frame);
		logic [XW-1:0] ext;
		ext = {{CODE_BITS{1'b0}}, frame};
		return ext[CODE_SHIFT +: CODE_BITS];
	endfunction

	logic [CODE_BITS-1:0] fcode, scode, bcode;
	logic [CODE_BITS:0]   ftwo, stwo;
	logic                 fpos, spos;
	logic [CODE_BITS-1:0] fmag, smag, sel_mag;
	logic                 fcen, scen;
	logic [PW-1:0]        lhs, rhs;
	logic                 drv_on;
	drive_t               drv;
	logic [MW-1:0]        bat;

	always_comb begin
		fcode = code_of(smp.forward_frame);
		scode = code_of(smp.side_frame);
		bcode = code_of(smp.battery_frame);
		ftwo  = {fcode, 1'b0};
		stwo  = {scode, 1'b0};
		fpos  = ftwo > {1'b0, FULL};
		spos  = stwo > {1'b0, FULL};
		fmag  = fpos ? CODE_BITS'(ftwo - {1'b0, FULL}) : CODE_BITS'({1'b0, FULL} - ftwo);
		smag  = spos ? CODE_BITS'(stwo - {1'b0, FULL}) : CODE_BITS'({1'b0, FULL} - stwo);
		fcen  = MW'(fmag) <= MW'(cfg.dead_band);
		scen  = MW'(smag) <= MW'(cfg.dead_band);
	end

	// only one axis ever drives, so one multiplier serves both
	always_comb begin
		sel_mag = scen ? fmag : smag;
		lhs = PW'(FULL) * PW'(smp.pwm_count) + PW'(sel_mag) * PW'(cfg.pwm_period);
		rhs = PW'(FULL) * PW'(cfg.pwm_period);
		drv_on = lhs > rhs;
	end

	always_comb begin
		drv = held;
		if (fcen && scen) begin
			drv = DRV_OFF;
		end else if (scen) begin
			drv = drv_on ? (fpos ? DRV_FORWARD : DRV_BACK) : DRV_OFF;
		end else if (fcen) begin
			drv = drv_on ? (spos ? DRV_RIGHT : DRV_LEFT) : DRV_OFF;
		end
	end

	always_comb begin
		bat = MW'(bcode);
		res = '0;
		held_nx = DRV_OFF;
		if (smp.power_on) begin
			held_nx = drv;
			res.drive = drv;
			if (bat >= MW'(cfg.green_min)) begin
				res.led_green = 1'b1;
			end else if (bat >= MW'(cfg.yellow_min)) begin
				res.led_yellow = 1'b1;
			end else if (bat >= MW'(cfg.orange_min)) begin
				res.led_orange = 1'b1;
			end else begin
				res.led_red = smp.pwm_count > cfg.blink_level;
			end
		end
	end

endmodule

`default_nettype wire

[bench/tb_joystick_motor_pwm_drive.sv]
// testbench for the joystick motor drive: random and directed samples checked against a predictor
`timescale 1ns / 100ps

module tb_joystick_motor_pwm_drive;
	import jmpd_pkg::*;

	localparam int CODE_BITS  = 10;
	localparam int CODE_SHIFT = 3;
	localparam int FULL       = (1 << CODE_BITS) - 1;
	localparam int SETTLE     = 4;

	typedef enum {MIX_FORWARD, MIX_TURN, MIX_CENTRED, MIX_BOTH_OFF, MIX_NOISE} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jmpd_sample_if sample ();
	jmpd_result_if result ();
	jmpd_cfg_if    cfg ();

	joystick_motor_pwm_drive #(
		.CODE_BITS(CODE_BITS),
		.CODE_SHIFT(CODE_SHIFT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	cfg_t    shadow;
	drive_t  held_drive;
	result_t expected_q[$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic logic [CODE_BITS-1:0] code_of(logic [FRAME_W-1:0] frame);
		return frame[CODE_SHIFT +: CODE_BITS];
	endfunction

	// magnitude of 2*code - FULL, sign returned separately
	function automatic int deflection(input logic [CODE_BITS-1:0] code, output bit positive);
		int twice;
		twice = 2 * int'(code);
		positive = twice > FULL;
		return positive ? twice - FULL : FULL - twice;
	endfunction

	// counter above P - mag*P/FULL, done without division
	function automatic bit drive_on(int mag, int n);
		return FULL * n + mag * int'(shadow.pwm_period) > FULL * int'(shadow.pwm_period);
	endfunction

	function automatic result_t predict_drive_leds(sample_t s);
		result_t r;
		int      fmag, smag, bat;
		bit      fpos, spos, fc, sc;
		r = '0;
		if (!s.power_on) begin
			held_drive = DRV_OFF;
			return r;
		end
		fmag = deflection(code_of(s.forward_frame), fpos);
		smag = deflection(code_of(s.side_frame), spos);
		bat  = int'(code_of(s.battery_frame));
		fc   = fmag <= int'(shadow.dead_band);
		sc   = smag <= int'(shadow.dead_band);
		if (fc && sc)
			held_drive = DRV_OFF;
		else if (sc)
			held_drive = drive_on(fmag, s.pwm_count) ? (fpos ? DRV_FORWARD : DRV_BACK) : DRV_OFF;
		else if (fc)
			held_drive = drive_on(smag, s.pwm_count) ? (spos ? DRV_RIGHT : DRV_LEFT) : DRV_OFF;
		// both axes off centre: pattern held as it was
		r.drive = held_drive;
		if (bat >= int'(shadow.green_min))
			r.led_green = 1'b1;
		else if (bat >= int'(shadow.yellow_min))
			r.led_yellow = 1'b1;
		else if (bat >= int'(shadow.orange_min))
			r.led_orange = 1'b1;
		else
			r.led_red = s.pwm_count > shadow.blink_level;
		return r;
	endfunction

	// ---------------- result side ----------------

	always @(negedge clk) result.ready = ($urandom_range(99) >= recv_idle_pct);

	function automatic void check_bit(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s expected %0b got %0b", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				check_bit("motor_a_forward", want.drive[0], result.motor_a_forward);
				check_bit("motor_a_reverse", want.drive[1], result.motor_a_reverse);
				check_bit("motor_b_forward", want.drive[2], result.motor_b_forward);
				check_bit("motor_b_reverse", want.drive[3], result.motor_b_reverse);
				check_bit("led_red", want.led_red, result.led_red);
				check_bit("led_orange", want.led_orange, result.led_orange);
				check_bit("led_yellow", want.led_yellow, result.led_yellow);
				check_bit("led_green", want.led_green, result.led_green);
			end
		end
	end

	// ---------------- sample and register channels ----------------

	task automatic send_sample(sample_t s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample.valid = 1'b0;
			@(negedge clk);
		end
		sample.valid         = 1'b1;
		sample.forward_frame = s.forward_frame;
		sample.side_frame    = s.side_frame;
		sample.battery_frame = s.battery_frame;
		sample.pwm_count     = s.pwm_count;
		sample.power_on      = s.power_on;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		expected_q.push_back(predict_drive_leds(s));
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample.valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_DEAD_BAND:   shadow.dead_band   = value;
			REG_PWM_PERIOD:  shadow.pwm_period  = value;
			REG_GREEN_MIN:   shadow.green_min   = value;
			REG_YELLOW_MIN:  shadow.yellow_min  = value;
			REG_ORANGE_MIN:  shadow.orange_min  = value;
			REG_BLINK_LEVEL: shadow.blink_level = value;
			default: ;
		endcase
	endtask

	// registers change only with the pipe empty
	task automatic load_settings(cfg_t c);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_DEAD_BAND, c.dead_band);
		write_reg(REG_PWM_PERIOD, c.pwm_period);
		write_reg(REG_GREEN_MIN, c.green_min);
		write_reg(REG_YELLOW_MIN, c.yellow_min);
		write_reg(REG_ORANGE_MIN, c.orange_min);
		write_reg(REG_BLINK_LEVEL, c.blink_level);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic int clip_code(int v);
		return (v < 0) ? 0 : (v > FULL) ? FULL : v;
	endfunction

	// code placed in bits 12..3, the rest of the frame random
	function automatic logic [FRAME_W-1:0] frame_with(int code);
		logic [FRAME_W-1:0] f;
		f = FRAME_W'($urandom);
		f[CODE_SHIFT +: CODE_BITS] = CODE_BITS'(code);
		return f;
	endfunction

	function automatic sample_t build(int fcode, int scode, int bcode, int n, bit pwr);
		sample_t s;
		s.forward_frame = frame_with(fcode);
		s.side_frame    = frame_with(scode);
		s.battery_frame = frame_with(bcode);
		s.pwm_count     = CNT_W'(n);
		s.power_on      = pwr;
		return s;
	endfunction

	function automatic int code_for(int mag, bit positive);
		int m;
		m = (mag < 1) ? 1 : (mag > FULL) ? FULL : mag;
		return positive ? (FULL + m) / 2 : (FULL - m) / 2;
	endfunction

	function automatic int odd_mag(int lo, int hi);
		int m;
		if (hi < lo)
			return lo;
		m = int'($urandom_range(hi, lo));
		if (m % 2 == 0)
			m = (m > lo) ? m - 1 : m + 1;
		return m;
	endfunction

	// a quarter of the codes sit right at the dead band edge
	function automatic int axis_code(bit centred);
		int db, mag;
		db = int'(shadow.dead_band);
		if ($urandom_range(3) == 0)
			mag = centred ? db - ((db % 2 == 0) ? 1 : 0) : db + ((db % 2 == 0) ? 1 : 2);
		else if (centred)
			mag = odd_mag(1, db);
		else
			mag = odd_mag(db + 1, FULL);
		return code_for(mag, $urandom_range(1) == 1);
	endfunction

	function automatic int battery_code();
		int pick, base;
		pick = int'($urandom_range(4));
		if (pick == 0)
			base = int'(shadow.green_min);
		else if (pick == 1)
			base = int'(shadow.yellow_min);
		else if (pick == 2)
			base = int'(shadow.orange_min);
		else
			return int'($urandom_range(FULL));
		return clip_code(base + int'($urandom_range(2)) - 1);
	endfunction

	function automatic int count_for(int mag);
		int p, pick;
		p    = int'(shadow.pwm_period);
		pick = int'($urandom_range(9));
		if (pick < 4)
			return clip_code(p - (mag * p) / FULL + int'($urandom_range(4)) - 2);
		if (pick == 4)
			return int'($urandom_range(1, 0)) * FULL;
		if (pick == 5)
			return clip_code(int'(shadow.blink_level) + int'($urandom_range(2)) - 1);
		return int'($urandom_range(FULL));
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		mix_t    mix;
		int      roll, fcode, scode, mag;
		bit      dir;
		roll = int'($urandom_range(99));
		if (roll < 38)
			mix = MIX_FORWARD;
		else if (roll < 76)
			mix = MIX_TURN;
		else if (roll < 84)
			mix = MIX_CENTRED;
		else if (roll < 92)
			mix = MIX_BOTH_OFF;
		else
			mix = MIX_NOISE;
		case (mix)
			MIX_FORWARD: begin
				fcode = axis_code(1'b0);
				scode = axis_code(1'b1);
			end
			MIX_TURN: begin
				fcode = axis_code(1'b1);
				scode = axis_code(1'b0);
			end
			MIX_CENTRED: begin
				fcode = axis_code(1'b1);
				scode = axis_code(1'b1);
			end
			MIX_BOTH_OFF: begin
				fcode = axis_code(1'b0);
				scode = axis_code(1'b0);
			end
			default: begin
				fcode = int'($urandom_range(FULL));
				scode = int'($urandom_range(FULL));
			end
		endcase
		mag = deflection(CODE_BITS'((mix == MIX_TURN) ? scode : fcode), dir);
		s = build(fcode, scode, battery_code(), count_for(mag), $urandom_range(19) != 0);
		if (mix == MIX_NOISE) begin
			s.forward_frame = FRAME_W'($urandom);
			s.side_frame    = FRAME_W'($urandom);
			s.battery_frame = FRAME_W'($urandom);
		end
		return s;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		int   a, b, d, swap;
		a = int'($urandom_range(FULL));
		b = int'($urandom_range(FULL));
		d = int'($urandom_range(FULL));
		// thresholds mostly falling, now and then left misordered
		if ($urandom_range(4) != 0) begin
			if (a < b) begin
				swap = a; a = b; b = swap;
			end
			if (b < d) begin
				swap = b; b = d; d = swap;
			end
			if (a < b) begin
				swap = a; a = b; b = swap;
			end
		end
		if ($urandom_range(3) == 0)
			c.dead_band = CFG_W'($urandom_range(FULL));
		else
			c.dead_band = CFG_W'($urandom_range(40));
		c.pwm_period  = CFG_W'($urandom_range(FULL, 1));
		c.green_min   = CFG_W'(a);
		c.yellow_min  = CFG_W'(b);
		c.orange_min  = CFG_W'(d);
		c.blink_level = CFG_W'($urandom_range(FULL));
		return c;
	endfunction

	// ---------------- tests ----------------

	// reset settings: every mode, band and threshold edges, power off, all-zero and all-one words
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 30;
		send_sample('{16'h0000, 16'h0000, 16'h0000, 10'd0, 1'b1});
		send_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 1'b1});
		send_sample(build(FULL, 511, 915, FULL, 1'b1));
		send_sample(build(FULL, 511, 914, 0, 1'b1));
		send_sample(build(FULL, 511, 813, 1, 1'b1));
		send_sample(build(0, 512, 812, 600, 1'b1));
		send_sample(build(0, 0, 608, 600, 1'b1));
		send_sample(build(511, FULL, 607, 501, 1'b1));
		send_sample(build(511, 0, 607, 500, 1'b1));
		send_sample(build(512, 511, 0, FULL, 1'b1));
		send_sample(build(518, 511, FULL, FULL, 1'b1));
		send_sample(build(517, 511, FULL, FULL, 1'b1));
		send_sample(build(511, 505, FULL, FULL, 1'b1));
		send_sample(build(518, 511, 0, 986, 1'b1));
		send_sample(build(518, 511, 0, 987, 1'b1));
		send_sample(build(FULL, 511, FULL, FULL, 1'b1));
		send_sample(build(FULL, 511, FULL, FULL, 1'b0));
		send_sample(build(0, 0, FULL, FULL, 1'b1));
		send_sample(build(FULL, FULL, 0, FULL, 1'b0));
		drain_results();
	endtask

	// extreme register values, zero period and misordered thresholds among them
	task automatic test_register_extremes();
		cfg_t corner[3];
		corner[0] = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd0};
		corner[1] = '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023};
		corner[2] = '{10'd1022, 10'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023};
		send_idle_pct = 10;
		recv_idle_pct = 10;
		foreach (corner[k]) begin
			load_settings(corner[k]);
			send_sample(build(FULL, 511, 0, 0, 1'b1));
			send_sample(build(FULL, 511, FULL, 1, 1'b1));
			send_sample(build(0, 512, 512, FULL, 1'b1));
			send_sample(build(511, FULL, 0, FULL, 1'b1));
			send_sample(build(512, 0, FULL, 500, 1'b1));
			send_sample(build(0, 0, 700, FULL, 1'b1));
			send_sample(build(511, 512, 0, FULL, 1'b1));
			send_sample(build(FULL, 511, FULL, FULL, 1'b0));
			repeat (10) send_sample(random_sample());
		end
		drain_results();
	endtask

	task automatic test_random(int count, int send_idle, int recv_idle);
		send_idle_pct = send_idle;
		recv_idle_pct = recv_idle;
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 0)
				load_settings(random_settings());
			// sender holds off mid-phase until every word has come back
			if (i == count / 2 + 37)
				drain_results();
			send_sample(random_sample());
		end
		drain_results();
	endtask

	initial begin
		sample.valid         = 1'b0;
		sample.forward_frame = '0;
		sample.side_frame    = '0;
		sample.battery_frame = '0;
		sample.pwm_count     = '0;
		sample.power_on      = 1'b0;
		cfg.valid            = 1'b0;
		cfg.index            = REG_DEAD_BAND;
		cfg.data             = '0;
		result.ready         = 1'b0;
		shadow = '{DEAD_BAND_RST, PWM_PERIOD_RST, GREEN_MIN_RST, YELLOW_MIN_RST,
			ORANGE_MIN_RST, BLINK_LEVEL_RST};
		held_drive = DRV_OFF;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_extremes();
		test_random(600, 17, 88);
		test_random(600, 88, 17);
		test_random(600, 0, 0);

		drain_results();
		repeat (SETTLE * 2) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
src/jmpd_pkg.sv
src/jmpd_ifs.sv
src/jmpd_decide.sv
src/joystick_motor_pwm_drive.sv
bench/tb_joystick_motor_pwm_drive.sv
